// ===== hdl/graph_depth_first_walk_top_assert.svh =====
// Assertion macros for the depth-first walk block.
// Used by graph_depth_first_walk_top; needs clk and rst in scope.
`ifndef GRAPH_DEPTH_FIRST_WALK_TOP_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_WALK_TOP_ASSERT_SVH

// cond must never hold outside reset
`define GDFW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// ante in one cycle implies cons in the next
`define GDFW_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// ante implies cons in the same cycle
`define GDFW_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/gdfw_pkg.sv =====
// Shared constants and types for the depth-first walk block.
// No dependencies.
package gdfw_pkg;

  localparam int MAX_VERTICES_DEF   = 64;
  localparam int MAX_LIST_NODES_DEF = 512;
  localparam int VERTEX_W           = 6;
  localparam int COUNT_W            = 7;

  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [1:0] ST_VISIT     = 2'd0;
  localparam logic [1:0] ST_EDGE_OK   = 2'd1;
  localparam logic [1:0] ST_EDGE_REJ  = 2'd2;
  localparam logic [1:0] ST_START_BAD = 2'd3;

  // request from the sequencer to the result stage
  typedef struct packed {
    logic                put;     // new visited vertex, held back one step
    logic                fin;     // walk over: release held vertex as last
    logic                direct;  // single status result, last set
    logic [1:0]          status;
    logic [VERTEX_W-1:0] vertex;
  } emit_cmd_t;

endpackage

// ===== hdl/gdfw_emit.sv =====
// Result stage: holds the newest visited vertex until it is known
// whether it is the final one. Depends on gdfw_pkg.
module gdfw_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  gdfw_pkg::emit_cmd_t            cmd,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [gdfw_pkg::VERTEX_W-1:0]  visited_vertex,
  output logic                           last
);

  logic                          held;
  logic [gdfw_pkg::VERTEX_W-1:0] held_vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.direct) begin
        done           <= 1'b1;
        status         <= cmd.status;
        visited_vertex <= '0;
        last           <= 1'b1;
      end else if (cmd.put) begin
        held        <= 1'b1;
        held_vertex <= cmd.vertex;
        if (held) begin
          done           <= 1'b1;
          status         <= gdfw_pkg::ST_VISIT;
          visited_vertex <= held_vertex;
          last           <= 1'b0;
        end
      end else if (cmd.fin) begin
        held           <= 1'b0;
        done           <= held;
        status         <= gdfw_pkg::ST_VISIT;
        visited_vertex <= held_vertex;
        last           <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/graph_depth_first_walk_top.sv =====
// Depth-first walk over an undirected graph kept as linked adjacency lists.
// Depends on gdfw_pkg, gdfw_emit and graph_depth_first_walk_top_assert.svh.
//
// Usage:
//   Command channel: an item transfers when start is high and busy is low.
//   kind 0 adds the undirected edge (vertex_a, vertex_b); kind 1 walks the
//   graph depth first from vertex_a.
//   Result channel: each result is on status/visited_vertex/last for one
//   cycle, marked by done. The receiver cannot stall; results are never
//   held off. last marks the final result of an item.
//   Configuration: cfg_we writes cfg_data into vertex_count; write only
//   while busy is low and no result is pending.
// Timing:
//   Edge add: busy while it links a node for a, reads the head of b and
//   links a node for b; the result comes in the same cycle busy drops.
//   Rejects are not busy; their result comes in the cycle after the transfer.
//   Search: each list node visited takes a top check and a node step,
//   each vertex pushed a push step and each frame popped a top check and
//   a pop step; the last result comes in the same cycle busy drops. The
//   pace is set by the single read port of the node memory and the head
//   memory, each read registered.
// Reset: all lists empty, node store empty, vertex_count = MAX_VERTICES.
// The node memory is not cleared; only written nodes are ever followed.
module graph_depth_first_walk_top #(
  parameter int MAX_VERTICES   = gdfw_pkg::MAX_VERTICES_DEF,
  parameter int MAX_LIST_NODES = gdfw_pkg::MAX_LIST_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind,
  input  logic [gdfw_pkg::VERTEX_W-1:0]  vertex_a,
  input  logic [gdfw_pkg::VERTEX_W-1:0]  vertex_b,
  input  logic                           cfg_we,
  input  logic [gdfw_pkg::COUNT_W-1:0]   cfg_data,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [gdfw_pkg::VERTEX_W-1:0]  visited_vertex,
  output logic                           last
);

  localparam int VW  = gdfw_pkg::VERTEX_W;
  localparam int CW  = gdfw_pkg::COUNT_W;
  localparam int VIW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PW  = $clog2(MAX_LIST_NODES);       // node pointer
  localparam int NUW = $clog2(MAX_LIST_NODES + 1);   // node fill count
  localparam int DW  = $clog2(MAX_VERTICES + 1);     // stack depth
  localparam int NW  = VW + PW + 1;                  // node word
  localparam int FW  = PW + 1;                       // stack frame word
  localparam logic [NUW:0] NODE_LIMIT = (NUW+1)'(MAX_LIST_NODES);
  localparam logic [CW-1:0] VMAX = CW'(MAX_VERTICES);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EA    = 4'd1;  // head of a arrived, link node
  localparam logic [3:0] S_EB_RD = 4'd2;  // read head of b
  localparam logic [3:0] S_EB    = 4'd3;  // link second node
  localparam logic [3:0] S_PUSH  = 4'd4;  // head of new vertex arrived
  localparam logic [3:0] S_TOP   = 4'd5;  // examine top frame cursor
  localparam logic [3:0] S_POP   = 4'd6;  // reload top frame from stack
  localparam logic [3:0] S_NODE  = 4'd7;  // list node arrived
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]     state, state_next;
  logic [CW-1:0]  vertex_count;
  logic [CW-1:0]  nv;

  // memories: list heads, list nodes, walk stack
  logic [PW-1:0]  heads [MAX_VERTICES];
  logic [NW-1:0]  nodes [MAX_LIST_NODES];
  logic [FW-1:0]  stack [MAX_VERTICES];
  logic [PW-1:0]  heads_q;
  logic [NW-1:0]  node_q;
  logic [FW-1:0]  stack_q;

  logic [MAX_VERTICES-1:0] head_ok;
  logic [MAX_VERTICES-1:0] visited;

  logic [VW-1:0]  va, vb, pv;
  logic [NUW-1:0] nodes_used;
  logic [DW-1:0]  depth;
  logic [CW-1:0]  count;
  logic [PW-1:0]  top_ptr;
  logic           top_ok;

  // read and write ports
  logic [VIW-1:0] hd_raddr;
  logic           hd_we;
  logic [VIW-1:0] hd_waddr;
  logic [PW-1:0]  hd_wdata;
  logic           nd_we;
  logic [PW-1:0]  nd_waddr;
  logic [NW-1:0]  nd_wdata;
  logic [PW-1:0]  nd_raddr;
  logic           st_we;
  logic [VIW-1:0] st_waddr;
  logic [VIW-1:0] st_raddr;

  gdfw_pkg::emit_cmd_t cmd;

  logic           accept;
  logic [VW-1:0]  nd_vertex;
  logic [PW-1:0]  nd_next;
  logic           nd_next_ok;
  logic           take_w;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // out-of-range register values clamp to 1..MAX_VERTICES
  always_comb begin
    if (vertex_count == '0)     nv = CW'(1);
    else if (vertex_count > VMAX) nv = VMAX;
    else                        nv = vertex_count;
  end

  assign {nd_vertex, nd_next, nd_next_ok} = node_q;
  assign take_w = (CW'(nd_vertex) < nv) && !visited[nd_vertex[VIW-1:0]] &&
                  (count < VMAX);

  always_ff @(posedge clk) begin
    heads_q <= heads[hd_raddr];
    if (hd_we) heads[hd_waddr] <= hd_wdata;
  end

  always_ff @(posedge clk) begin
    node_q <= nodes[nd_raddr];
    if (nd_we) nodes[nd_waddr] <= nd_wdata;
  end

  always_ff @(posedge clk) begin
    stack_q <= stack[st_raddr];
    if (st_we) stack[st_waddr] <= {top_ok, top_ptr};
  end

  always_comb begin
    state_next = state;
    hd_raddr   = va[VIW-1:0];
    hd_we      = 1'b0;
    hd_waddr   = va[VIW-1:0];
    hd_wdata   = nodes_used[PW-1:0];
    nd_we      = 1'b0;
    nd_waddr   = nodes_used[PW-1:0];
    nd_wdata   = {vb, heads_q, head_ok[va[VIW-1:0]]};
    nd_raddr   = top_ptr;
    st_we      = 1'b0;
    st_waddr   = VIW'(depth - DW'(1));
    st_raddr   = VIW'(depth - DW'(2));
    cmd        = '0;
    case (state)
      S_IDLE: begin
        hd_raddr = vertex_a[VIW-1:0];
        if (accept) begin
          if (kind == gdfw_pkg::KIND_EDGE) begin
            if (CW'(vertex_a) >= nv || CW'(vertex_b) >= nv ||
                ((NUW+1)'(nodes_used) + (NUW+1)'(2)) > NODE_LIMIT) begin
              cmd.direct = 1'b1;
              cmd.status = gdfw_pkg::ST_EDGE_REJ;
            end else begin
              state_next = S_EA;
            end
          end else if (CW'(vertex_a) >= nv) begin
            cmd.direct = 1'b1;
            cmd.status = gdfw_pkg::ST_START_BAD;
          end else begin
            state_next = S_PUSH;
          end
        end
      end
      S_EA: begin
        nd_we      = 1'b1;
        hd_we      = 1'b1;
        state_next = S_EB_RD;
      end
      S_EB_RD: begin
        hd_raddr   = vb[VIW-1:0];
        state_next = S_EB;
      end
      S_EB: begin
        nd_we      = 1'b1;
        nd_waddr   = PW'(nodes_used + NUW'(1));
        nd_wdata   = {va, heads_q, head_ok[vb[VIW-1:0]]};
        hd_we      = 1'b1;
        hd_waddr   = vb[VIW-1:0];
        hd_wdata   = PW'(nodes_used + NUW'(1));
        cmd.direct = 1'b1;
        cmd.status = gdfw_pkg::ST_EDGE_OK;
        state_next = S_IDLE;
      end
      S_PUSH: begin
        // spill the current top frame, new frame lives in registers
        st_we      = (depth != '0);
        cmd.put    = 1'b1;
        cmd.vertex = pv;
        state_next = S_TOP;
      end
      S_TOP: begin
        if (!top_ok) begin
          if (depth == DW'(1)) state_next = S_FIN;
          else                 state_next = S_POP;
        end else begin
          state_next = S_NODE;
        end
      end
      S_POP: begin
        state_next = S_TOP;
      end
      S_NODE: begin
        hd_raddr = nd_vertex[VIW-1:0];
        if (take_w) state_next = S_PUSH;
        else        state_next = S_TOP;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VMAX;
      head_ok      <= '0;
      visited      <= '0;
      nodes_used   <= '0;
      depth        <= '0;
      count        <= '0;
      top_ok       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) vertex_count <= cfg_data;
      case (state)
        S_IDLE: begin
          if (accept) begin
            va    <= vertex_a;
            vb    <= vertex_b;
            pv    <= vertex_a;
            if (kind == gdfw_pkg::KIND_SEARCH) begin
              visited <= '0;
              depth   <= '0;
              count   <= '0;
            end
          end
        end
        S_EA: begin
          head_ok[va[VIW-1:0]] <= 1'b1;
        end
        S_EB: begin
          head_ok[vb[VIW-1:0]] <= 1'b1;
          nodes_used           <= nodes_used + NUW'(2);
        end
        S_PUSH: begin
          top_ptr              <= heads_q;
          top_ok               <= head_ok[pv[VIW-1:0]];
          visited[pv[VIW-1:0]] <= 1'b1;
          depth                <= depth + DW'(1);
          count                <= count + CW'(1);
        end
        S_TOP: begin
          if (!top_ok) depth <= depth - DW'(1);
        end
        S_POP: begin
          {top_ok, top_ptr} <= stack_q;
        end
        S_NODE: begin
          top_ptr <= nd_next;
          top_ok  <= nd_next_ok;
          if (take_w) pv <= nd_vertex;
        end
        default: begin
        end
      endcase
    end
  end

  gdfw_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .done           (done),
    .status         (status),
    .visited_vertex (visited_vertex),
    .last           (last)
  );

`include "graph_depth_first_walk_top_assert.svh"

  `GDFW_NEVER(a_depth_bound, depth > DW'(MAX_VERTICES), "walk stack overflow")
  `GDFW_NEVER(a_nodes_bound, (NUW+1)'(nodes_used) > NODE_LIMIT, "node store overrun")
  `GDFW_SAME(a_mid_result_busy, done && !last, busy, "non-final result while idle")
  `GDFW_NEXT(a_accept_busy, accept && !cmd.direct, busy, "accepted item not worked")

endmodule
